@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the RTL (included by i2c_bit_level_master).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define CHK_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("check failed");

// cons must hold whenever ante holds, same edge
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

`endif

@@ rtl/core/i2cblm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cblm_pkg
// Types, codes and helpers for the I2C bit-level master.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cblm_pkg;

    // hold counter width
    localparam int CNT_W = 8;
    localparam int HOLD_CMP_W = (CNT_W > 8) ? CNT_W : 8;
    localparam logic [CNT_W-1:0] HOLD_MAX = '1;

    // command codes
    localparam logic [2:0] FUNC_NONE  = 3'd0;
    localparam logic [2:0] FUNC_START = 3'd1;
    localparam logic [2:0] FUNC_STOP  = 3'd2;
    localparam logic [2:0] FUNC_SEND  = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;
    localparam logic [2:0] FUNC_WACK  = 3'd5;
    localparam logic [2:0] FUNC_ACK   = 3'd6;
    localparam logic [2:0] FUNC_NACK  = 3'd7;

    // register indexes
    localparam logic [1:0] CFG_SHORT_HOLD = 2'd0;
    localparam logic [1:0] CFG_LONG_HOLD  = 2'd1;
    localparam logic [1:0] CFG_POLL_LIMIT = 2'd2;

    localparam logic [7:0] SHORT_HOLD_RST = 8'd2;
    localparam logic [7:0] LONG_HOLD_RST  = 8'd30;
    localparam logic [7:0] POLL_LIMIT_RST = 8'd250;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       ack_after_read;
        logic       sda_level;
        logic       tick;
    } t_in_item;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } t_out_item;

    // zero counts as one tick, saturate to the counter range
    function automatic logic [CNT_W-1:0] load_hold(input logic [7:0] v);
        logic [HOLD_CMP_W-1:0] h;
        h = (v == 8'd0) ? HOLD_CMP_W'(1) : HOLD_CMP_W'(v);
        if (h > HOLD_CMP_W'(HOLD_MAX)) begin
            return HOLD_MAX;
        end
        return h[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/i2c_bit_level_master.sv @@
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// I2C master that sequences SCL and SDA pin levels one clock item at a time.
//
// Each input item stands for one clock of the engine: a command code (taken
// only while idle), the sampled SDA level and a timebase tick. Every accepted
// item yields exactly one result item with the pin levels after that step,
// busy/done status, the last received byte and the ack-failure flag. The
// whole step is one pass of logic from the state registers into the result
// register, and a new item is accepted every cycle as long as the result
// register is empty or being drained in that cycle.
// Holds are counted in timebase ticks; a zero hold register acts as one tick.
// Wait-for-ACK samples SDA at the end of each short hold and, past the poll
// limit, runs a stop sequence and raises ack_failed. Configuration writes
// (short hold, long hold, poll limit) are always accepted and must only be
// issued while the engine is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module i2c_bit_level_master (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire i2cblm_pkg::t_in_item   i_in,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output i2cblm_pkg::t_out_item       o_out,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire  [1:0]                  i_cfg_index,
    input  wire  [7:0]                  i_cfg_data
);

    // sequencer phases
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_ST_A     = 4'd1;
    localparam logic [3:0] PH_ST_B     = 4'd2;
    localparam logic [3:0] PH_SP_A     = 4'd3;
    localparam logic [3:0] PH_SP_B     = 4'd4;
    localparam logic [3:0] PH_WA_POLL  = 4'd5;
    localparam logic [3:0] PH_TX_LOW   = 4'd6;
    localparam logic [3:0] PH_TX_HIGH  = 4'd7;
    localparam logic [3:0] PH_TX_TAIL  = 4'd8;
    localparam logic [3:0] PH_RX_SETUP = 4'd9;
    localparam logic [3:0] PH_RX_LOW   = 4'd10;
    localparam logic [3:0] PH_RX_HIGH  = 4'd11;
    localparam logic [3:0] PH_AK_LOW   = 4'd12;
    localparam logic [3:0] PH_AK_HIGH  = 4'd13;

    // config registers
    logic [7:0] r_short_hold, r_long_hold, r_poll_limit;

    // engine state
    logic [3:0]                   r_phase,  n_phase;
    logic [3:0]                   r_bits,   n_bits;
    logic [i2cblm_pkg::CNT_W-1:0] r_hold,   n_hold;
    logic [7:0]                   r_shift,  n_shift;
    logic [7:0]                   r_polls,  n_polls;
    logic                         r_scl,    n_scl;
    logic                         r_sda,    n_sda;
    logic                         r_drive,  n_drive;
    logic                         r_fail,   n_fail;
    logic                         r_ack,    n_ack;
    logic [7:0]                   r_rx,     n_rx;
    logic                         n_done;

    // result register
    logic                         r_out_valid;
    i2cblm_pkg::t_out_item        r_out;

    logic in_fire;
    logic [i2cblm_pkg::CNT_W-1:0] short_ld, long_ld;
    logic [3:0] bits_inc;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign short_ld = i2cblm_pkg::load_hold(r_short_hold);
    assign long_ld  = i2cblm_pkg::load_hold(r_long_hold);
    assign bits_inc = r_bits + 4'd1;

    // one engine step
    always_comb begin
        n_phase = r_phase;
        n_bits  = r_bits;
        n_hold  = r_hold;
        n_shift = r_shift;
        n_polls = r_polls;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_drive = r_drive;
        n_fail  = r_fail;
        n_ack   = r_ack;
        n_rx    = r_rx;
        n_done  = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_in.func != i2cblm_pkg::FUNC_NONE) begin
                n_bits = 4'd0;
            end
            unique case (i_in.func) inside
                i2cblm_pkg::FUNC_START: begin
                    n_drive = 1'b1; n_scl = 1'b1; n_sda = 1'b1;
                    n_hold  = long_ld; n_phase = PH_ST_A;
                end
                i2cblm_pkg::FUNC_STOP: begin
                    n_drive = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                    n_hold  = long_ld; n_phase = PH_SP_A;
                end
                i2cblm_pkg::FUNC_SEND: begin
                    // first data bit goes out with SCL low
                    n_drive = 1'b1; n_scl = 1'b0;
                    n_sda   = i_in.tx_byte[7];
                    n_shift = {i_in.tx_byte[6:0], 1'b0};
                    n_hold  = short_ld; n_phase = PH_TX_LOW;
                end
                i2cblm_pkg::FUNC_READ: begin
                    n_drive = 1'b0; n_ack = i_in.ack_after_read; n_shift = 8'd0;
                    n_hold  = long_ld; n_phase = PH_RX_SETUP;
                end
                i2cblm_pkg::FUNC_WACK: begin
                    n_drive = 1'b0; n_sda = 1'b1; n_scl = 1'b1;
                    n_fail  = 1'b0; n_polls = 8'd0;
                    n_hold  = short_ld; n_phase = PH_WA_POLL;
                end
                i2cblm_pkg::FUNC_ACK, i2cblm_pkg::FUNC_NACK: begin
                    n_scl = 1'b0; n_drive = 1'b1;
                    n_sda = (i_in.func == i2cblm_pkg::FUNC_NACK);
                    n_hold = short_ld; n_phase = PH_AK_LOW;
                end
                default: ;
            endcase
        end else if (i_in.tick) begin
            if (r_hold > i2cblm_pkg::CNT_W'(1)) begin
                n_hold = r_hold - i2cblm_pkg::CNT_W'(1);
            end else begin
                // hold expired: take the next step of the sequence
                n_hold = '0;
                unique case (r_phase)
                    PH_ST_A: begin
                        n_sda = 1'b0; n_hold = short_ld; n_phase = PH_ST_B;
                    end
                    PH_ST_B: begin
                        n_scl = 1'b0; n_phase = PH_IDLE; n_done = 1'b1;
                    end
                    PH_SP_A: begin
                        n_scl = 1'b1; n_hold = short_ld; n_phase = PH_SP_B;
                    end
                    PH_SP_B: begin
                        n_sda = 1'b1; n_phase = PH_IDLE; n_done = 1'b1;
                    end
                    PH_WA_POLL: begin
                        if (!i_in.sda_level) begin
                            n_scl = 1'b0; n_phase = PH_IDLE; n_done = 1'b1;
                        end else if (r_polls >= r_poll_limit) begin
                            // timed out: flag and release the bus with a stop
                            n_fail  = 1'b1;
                            n_drive = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                            n_hold  = long_ld; n_phase = PH_SP_A;
                        end else begin
                            n_polls = r_polls + 8'd1;
                            n_hold  = short_ld;
                        end
                    end
                    PH_TX_LOW: begin
                        n_scl = 1'b1; n_hold = short_ld; n_phase = PH_TX_HIGH;
                    end
                    PH_TX_HIGH: begin
                        n_scl = 1'b0; n_hold = short_ld; n_phase = PH_TX_TAIL;
                    end
                    PH_TX_TAIL: begin
                        n_bits = bits_inc;
                        if (bits_inc >= 4'd8) begin
                            n_phase = PH_IDLE; n_done = 1'b1;
                        end else begin
                            n_sda   = r_shift[7];
                            n_shift = {r_shift[6:0], 1'b0};
                            n_hold  = short_ld; n_phase = PH_TX_LOW;
                        end
                    end
                    PH_RX_SETUP: begin
                        n_scl = 1'b0; n_hold = short_ld; n_phase = PH_RX_LOW;
                    end
                    PH_RX_LOW: begin
                        n_scl   = 1'b1;
                        n_shift = {r_shift[6:0], i_in.sda_level};
                        n_hold  = short_ld; n_phase = PH_RX_HIGH;
                    end
                    PH_RX_HIGH: begin
                        n_bits = bits_inc;
                        if (bits_inc >= 4'd8) begin
                            // byte complete, follow with ACK or NACK
                            n_rx  = r_shift;
                            n_scl = 1'b0; n_drive = 1'b1; n_sda = !r_ack;
                            n_hold = short_ld; n_phase = PH_AK_LOW;
                        end else begin
                            n_scl = 1'b0; n_hold = short_ld; n_phase = PH_RX_LOW;
                        end
                    end
                    PH_AK_LOW: begin
                        n_scl = 1'b1; n_hold = short_ld; n_phase = PH_AK_HIGH;
                    end
                    PH_AK_HIGH: begin
                        n_scl = 1'b0; n_phase = PH_IDLE; n_done = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_hold <= i2cblm_pkg::SHORT_HOLD_RST;
            r_long_hold  <= i2cblm_pkg::LONG_HOLD_RST;
            r_poll_limit <= i2cblm_pkg::POLL_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                i2cblm_pkg::CFG_SHORT_HOLD: r_short_hold <= i_cfg_data;
                i2cblm_pkg::CFG_LONG_HOLD:  r_long_hold  <= i_cfg_data;
                i2cblm_pkg::CFG_POLL_LIMIT: r_poll_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // engine state advances once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bits  <= 4'd0;
            r_hold  <= '0;
            r_shift <= 8'd0;
            r_polls <= 8'd0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_drive <= 1'b1;
            r_fail  <= 1'b0;
            r_ack   <= 1'b0;
            r_rx    <= 8'd0;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_bits  <= n_bits;
            r_hold  <= n_hold;
            r_shift <= n_shift;
            r_polls <= n_polls;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_drive <= n_drive;
            r_fail  <= n_fail;
            r_ack   <= n_ack;
            r_rx    <= n_rx;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out.scl        <= n_scl;
            r_out.sda_out    <= n_sda;
            r_out.sda_drive  <= n_drive;
            r_out.busy_res   <= (n_phase != PH_IDLE);
            r_out.done_res   <= n_done;
            r_out.rx_byte    <= n_rx;
            r_out.ack_failed <= n_fail;
        end
    end

    // a running sequence always has a hold loaded
    `CHK_IMPLY(a_hold_loaded, i_clk, i_rst_n, r_phase != PH_IDLE, r_hold != '0)
    // a finished command reports not busy
    `CHK_IMPLY(a_done_idle, i_clk, i_rst_n, o_out_valid && o_out.done_res, !o_out.busy_res)
    // the master owns SDA through every transmit phase
    `CHK_IMPLY(a_tx_drive, i_clk, i_rst_n,
        r_phase == PH_TX_LOW || r_phase == PH_TX_HIGH || r_phase == PH_TX_TAIL, r_drive)

endmodule

`default_nettype wire

@@ sim/i2cblm_checker.sv @@
// ----------------------------------------------------------------------------
// i2cblm_checker
// Watches the item, result and register channels of the I2C bit-level master,
// keeps its own copy of the pin sequencer, and compares every result item
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module i2cblm_checker
    import i2cblm_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_in_ready,
    input  t_in_item   i_in,
    input  wire        i_out_valid,
    input  wire        i_out_ready,
    input  t_out_item  i_out,
    input  wire        i_cfg_valid,
    input  wire        i_cfg_ready,
    input  wire  [1:0] i_cfg_index,
    input  wire  [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending,
    output logic       o_busy
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_START_SETUP, SEQ_START_FALL, SEQ_STOP_SETUP, SEQ_STOP_RISE,
        SEQ_ACK_POLL, SEQ_TX_SETUP, SEQ_TX_HIGH, SEQ_TX_TAIL, SEQ_RX_WAIT,
        SEQ_RX_LOW, SEQ_RX_HIGH, SEQ_ACKBIT_LOW, SEQ_ACKBIT_HIGH
    } seq_e;

    // register copies
    logic [7:0]       short_hold, long_hold, poll_limit;
    // sequencer copy
    seq_e             seq;
    logic [3:0]       bit_idx;
    logic [CNT_W-1:0] hold_left;
    logic [7:0]       shifter, poll_cnt, rx_last;
    logic             scl_lvl, sda_lvl, sda_drv, ack_fail, ack_choice;

    t_out_item        expected_q[$];
    int               mismatches = 0;

    // zero acts as one tick, saturate at the counter range
    function automatic logic [CNT_W-1:0] hold_ticks(input logic [7:0] v);
        int unsigned h;
        h = (v == 8'd0) ? 1 : int'(v);
        if (h > int'(HOLD_MAX))
            h = int'(HOLD_MAX);
        return CNT_W'(h);
    endfunction

    task automatic go_stop();
        sda_drv   = 1'b1;
        scl_lvl   = 1'b0;
        sda_lvl   = 1'b0;
        hold_left = hold_ticks(long_hold);
        seq       = SEQ_STOP_SETUP;
    endtask

    task automatic go_ackbit(input logic lvl);
        scl_lvl   = 1'b0;
        sda_drv   = 1'b1;
        sda_lvl   = lvl;
        hold_left = hold_ticks(short_hold);
        seq       = SEQ_ACKBIT_LOW;
    endtask

    task automatic drive_next_bit();
        sda_lvl   = shifter[7];
        shifter   = shifter << 1;
        hold_left = hold_ticks(short_hold);
        seq       = SEQ_TX_SETUP;
    endtask

    // next pin step once the running hold has run out
    task automatic hold_expired(input logic sda_in, output bit fin);
        fin = 1'b0;
        case (seq)
            SEQ_START_SETUP: begin
                sda_lvl   = 1'b0;
                hold_left = hold_ticks(short_hold);
                seq       = SEQ_START_FALL;
            end
            SEQ_START_FALL: begin
                scl_lvl = 1'b0;
                seq     = SEQ_IDLE;
                fin     = 1'b1;
            end
            SEQ_STOP_SETUP: begin
                scl_lvl   = 1'b1;
                hold_left = hold_ticks(short_hold);
                seq       = SEQ_STOP_RISE;
            end
            SEQ_STOP_RISE: begin
                sda_lvl = 1'b1;
                seq     = SEQ_IDLE;
                fin     = 1'b1;
            end
            SEQ_ACK_POLL: begin
                if (!sda_in) begin
                    scl_lvl = 1'b0;
                    seq     = SEQ_IDLE;
                    fin     = 1'b1;
                end else if (poll_cnt >= poll_limit) begin
                    ack_fail = 1'b1;
                    go_stop();
                end else begin
                    poll_cnt  = poll_cnt + 8'd1;
                    hold_left = hold_ticks(short_hold);
                end
            end
            SEQ_TX_SETUP: begin
                scl_lvl   = 1'b1;
                hold_left = hold_ticks(short_hold);
                seq       = SEQ_TX_HIGH;
            end
            SEQ_TX_HIGH: begin
                scl_lvl   = 1'b0;
                hold_left = hold_ticks(short_hold);
                seq       = SEQ_TX_TAIL;
            end
            SEQ_TX_TAIL: begin
                bit_idx = bit_idx + 4'd1;
                if (bit_idx >= 4'd8) begin
                    seq = SEQ_IDLE;
                    fin = 1'b1;
                end else begin
                    drive_next_bit();
                end
            end
            SEQ_RX_WAIT: begin
                scl_lvl   = 1'b0;
                hold_left = hold_ticks(short_hold);
                seq       = SEQ_RX_LOW;
            end
            SEQ_RX_LOW: begin
                scl_lvl   = 1'b1;
                shifter   = {shifter[6:0], sda_in};
                hold_left = hold_ticks(short_hold);
                seq       = SEQ_RX_HIGH;
            end
            SEQ_RX_HIGH: begin
                bit_idx = bit_idx + 4'd1;
                if (bit_idx >= 4'd8) begin
                    rx_last = shifter;
                    go_ackbit(!ack_choice);
                end else begin
                    scl_lvl   = 1'b0;
                    hold_left = hold_ticks(short_hold);
                    seq       = SEQ_RX_LOW;
                end
            end
            SEQ_ACKBIT_LOW: begin
                scl_lvl   = 1'b1;
                hold_left = hold_ticks(short_hold);
                seq       = SEQ_ACKBIT_HIGH;
            end
            SEQ_ACKBIT_HIGH: begin
                scl_lvl = 1'b0;
                seq     = SEQ_IDLE;
                fin     = 1'b1;
            end
            default: seq = SEQ_IDLE;
        endcase
    endtask

    task automatic begin_command(input t_in_item it);
        bit_idx = 4'd0;
        case (it.func)
            FUNC_START: begin
                sda_drv   = 1'b1;
                scl_lvl   = 1'b1;
                sda_lvl   = 1'b1;
                hold_left = hold_ticks(long_hold);
                seq       = SEQ_START_SETUP;
            end
            FUNC_STOP: go_stop();
            FUNC_SEND: begin
                sda_drv = 1'b1;
                scl_lvl = 1'b0;
                shifter = it.tx_byte;
                drive_next_bit();
            end
            FUNC_READ: begin
                sda_drv    = 1'b0;
                ack_choice = it.ack_after_read;
                shifter    = 8'd0;
                hold_left  = hold_ticks(long_hold);
                seq        = SEQ_RX_WAIT;
            end
            FUNC_WACK: begin
                sda_drv   = 1'b0;
                sda_lvl   = 1'b1;
                scl_lvl   = 1'b1;
                ack_fail  = 1'b0;
                poll_cnt  = 8'd0;
                hold_left = hold_ticks(short_hold);
                seq       = SEQ_ACK_POLL;
            end
            FUNC_ACK:  go_ackbit(1'b0);
            FUNC_NACK: go_ackbit(1'b1);
            default: ;
        endcase
    endtask

    // one engine clock per item
    task automatic step_engine(input t_in_item it, output t_out_item res);
        bit fin;
        fin = 1'b0;
        if (seq == SEQ_IDLE) begin
            if (it.func != FUNC_NONE)
                begin_command(it);
        end else if (it.tick) begin
            if (hold_left > CNT_W'(1)) begin
                hold_left = hold_left - CNT_W'(1);
            end else begin
                hold_left = '0;
                hold_expired(it.sda_level, fin);
            end
        end
        res.scl        = scl_lvl;
        res.sda_out    = sda_lvl;
        res.sda_drive  = sda_drv;
        res.busy_res   = (seq != SEQ_IDLE);
        res.done_res   = fin;
        res.rx_byte    = rx_last;
        res.ack_failed = ack_fail;
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            short_hold = SHORT_HOLD_RST;
            long_hold  = LONG_HOLD_RST;
            poll_limit = POLL_LIMIT_RST;
            seq        = SEQ_IDLE;
            bit_idx    = 4'd0;
            hold_left  = '0;
            shifter    = 8'd0;
            poll_cnt   = 8'd0;
            rx_last    = 8'd0;
            scl_lvl    = 1'b1;
            sda_lvl    = 1'b1;
            sda_drv    = 1'b1;
            ack_fail   = 1'b0;
            ack_choice = 1'b0;
            expected_q.delete();
        end else begin
            // compare first: a result leaving now was predicted earlier
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result item with nothing expected: %h", $time, i_out);
                end else begin
                    want = expected_q.pop_front();
                    if (i_out !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"[%0t] mismatch exp scl=%b sda=%b drv=%b busy=%b",
                                      " done=%b rx=%h fail=%b | got scl=%b sda=%b drv=%b",
                                      " busy=%b done=%b rx=%h fail=%b"}, $time,
                                     want.scl, want.sda_out, want.sda_drive,
                                     want.busy_res, want.done_res, want.rx_byte,
                                     want.ack_failed, i_out.scl, i_out.sda_out,
                                     i_out.sda_drive, i_out.busy_res, i_out.done_res,
                                     i_out.rx_byte, i_out.ack_failed);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SHORT_HOLD: short_hold = i_cfg_data;
                    CFG_LONG_HOLD:  long_hold  = i_cfg_data;
                    CFG_POLL_LIMIT: poll_limit = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                step_engine(i_in, want);
                expected_q.push_back(want);
            end
        end
        o_pending    = expected_q.size();
        o_busy       = (seq != SEQ_IDLE);
        o_fail_count = mismatches;
    end

endmodule

@@ sim/tb_i2c_bit_level_master.sv @@
// ----------------------------------------------------------------------------
// tb_i2c_bit_level_master
// Stimulus and verdict for the I2C bit-level master.
//
// Each input item is one engine clock: command, sampled SDA and timebase
// tick. A directed run walks every command with a zero short hold, a long
// hold of one and a zero poll limit, then random bursts run under several
// hold/limit settings, from all zeros up to 255. The checker beside the DUT
// predicts and compares results.
module tb_i2c_bit_level_master;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cblm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // SDA patterns for directed runs
    localparam int SDA_LOW    = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_TOGGLE = 2;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_in_item   in_item   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = CFG_SHORT_HOLD;
    logic [7:0] cfg_data  = 8'd0;

    int         chk_fails;
    int         chk_pending;
    logic       chk_busy;

    int unsigned cyc_count = 0;

    always #5 clk = ~clk;

    i2c_bit_level_master u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    i2cblm_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending),
        .o_busy       (chk_busy)
    );

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk) begin
        cyc_count++;
        if (cyc_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: the stall pattern periodically switches at random between always
    // ready, one stall in four, alternating runs of stall and ready, and coin flips.
    int rx_cyc  = 0;
    int rx_mode = 0;
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready = 1'b0;
        end else begin
            rx_cyc++;
            if (rx_cyc % 97 == 0)
                rx_mode = $urandom_range(3);
            case (rx_mode)
                0: out_ready = 1'b1;
                1: out_ready = (rx_cyc % 4) != 0;
                2: out_ready = (rx_cyc % 16) < 8;
                default: out_ready = 1'($urandom_range(1));
            endcase
        end
    end

    // Present one item and hold it until taken; returns on the next falling
    // edge with valid still high, so back-to-back items need no gap.
    task automatic push_item(input t_in_item it);
        in_valid = 1'b1;
        in_item  = it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Wait until every predicted result has come back.
    task automatic wait_results();
        in_valid = 1'b0;
        while (chk_pending != 0)
            @(negedge clk);
    endtask

    // Feed ticking no-op items until the engine is idle, then let results
    // drain and rewrite all three registers.
    task automatic set_config(input logic [7:0] sh, input logic [7:0] lh,
                              input logic [7:0] pl);
        t_in_item it;
        while (chk_busy) begin
            it           = '0;
            it.func      = FUNC_NONE;
            it.tx_byte   = 8'($urandom);
            it.sda_level = 1'($urandom);
            it.tick      = 1'b1;
            push_item(it);
        end
        wait_results();
        write_reg(CFG_SHORT_HOLD, sh);
        write_reg(CFG_LONG_HOLD, lh);
        write_reg(CFG_POLL_LIMIT, pl);
    endtask

    // Directed: one command item, then n_after ticking items that carry
    // busy_func (ignored while the command runs).
    task automatic run_cmd(input logic [2:0] f, input logic [7:0] tx, input logic ackr,
                           input int sda_mode, input int n_after,
                           input logic [2:0] busy_func);
        t_in_item it;
        it = '{func: f, tx_byte: tx, ack_after_read: ackr,
               sda_level: (sda_mode == SDA_HIGH), tick: 1'b1};
        push_item(it);
        it.func = busy_func;
        for (int k = 0; k < n_after; k++) begin
            if (sda_mode == SDA_TOGGLE)
                it.sda_level = 1'(k);
            push_item(it);
        end
    endtask

    // Random items in bursts with random gaps; some bursts run without a gap.
    task automatic run_random(input int n, input int tick_pct, input int sda_hi_pct,
                              input int cmd_pct);
        t_in_item it;
        int       left;
        int       burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(20, 1);
            while (burst > 0 && left > 0) begin
                it.func = ($urandom_range(99) < cmd_pct) ? 3'($urandom_range(7, 1))
                                                         : FUNC_NONE;
                it.tx_byte        = 8'($urandom);
                it.ack_after_read = 1'($urandom);
                it.sda_level      = $urandom_range(99) < sda_hi_pct;
                it.tick           = $urandom_range(99) < tick_pct;
                push_item(it);
                burst--;
                left--;
            end
            if ($urandom_range(3) != 0) begin
                in_valid = 1'b0;
                repeat ($urandom_range(6, 1)) @(negedge clk);
            end
        end
    endtask

    initial begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero holds act as one tick, zero poll limit fails on
        // the first high poll. Send carries a stop that must be ignored.
        set_config(8'd0, 8'd1, 8'd0);
        run_cmd(FUNC_START, 8'h00, 1'b0, SDA_LOW,    2,  FUNC_NONE);
        run_cmd(FUNC_SEND,  8'hFF, 1'b0, SDA_LOW,    24, FUNC_STOP);
        run_cmd(FUNC_WACK,  8'h00, 1'b0, SDA_LOW,    1,  FUNC_NONE);
        run_cmd(FUNC_WACK,  8'h00, 1'b0, SDA_HIGH,   3,  FUNC_NONE);
        run_cmd(FUNC_READ,  8'h5A, 1'b0, SDA_TOGGLE, 19, FUNC_NONE);
        run_cmd(FUNC_ACK,   8'h00, 1'b1, SDA_LOW,    2,  FUNC_NONE);
        run_cmd(FUNC_NACK,  8'hFF, 1'b1, SDA_HIGH,   2,  FUNC_NONE);
        run_cmd(FUNC_STOP,  8'h00, 1'b0, SDA_LOW,    2,  FUNC_NONE);

        // Short holds, small poll limit, SDA mostly high: frequent timeouts.
        set_config(8'd1, 8'd2, 8'd3);
        run_random(125, 70, 60, 40);
        // sender holds off until the result queue is empty
        wait_results();
        run_random(125, 70, 60, 40);

        set_config(8'd3, 8'd5, 8'd1);
        run_random(200, 50, 50, 30);

        // Largest holds: one start spans both full-length holds.
        set_config(8'd255, 8'd255, 8'd255);
        run_cmd(FUNC_START, 8'h3C, 1'b1, SDA_HIGH, 0, FUNC_NONE);
        run_random(520, 100, 50, 0);

        // Largest poll limit with SDA stuck high: times out after 256 polls.
        set_config(8'd1, 8'd1, 8'd255);
        run_cmd(FUNC_WACK, 8'hC3, 1'b0, SDA_HIGH, 0, FUNC_NONE);
        run_random(270, 100, 100, 0);

        // Reset-like timing, slaves mostly acknowledge.
        set_config(8'd2, 8'd30, 8'd250);
        run_random(300, 60, 10, 30);

        set_config(8'd0, 8'd0, 8'd0);
        run_random(200, 80, 50, 50);

        wait_results();
        repeat (8) @(negedge clk);
        if (chk_fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/i2cblm_pkg.sv
rtl/core/i2c_bit_level_master.sv
sim/i2cblm_checker.sv
sim/tb_i2c_bit_level_master.sv
